// File: hdl/v2r_pkg.sv
// shared types, constants and elaboration-time helpers for the vector rotator
package v2r_pkg;

   localparam int ITERATIONS_DEF = 16;
   localparam int DATA_WIDTH_DEF = 32;

   localparam int VEC_W       = 32;
   localparam int ANG_W       = 20;
   localparam int ANG_IN_FRAC = 16;
   localparam int GAIN_FRAC   = 30;
   localparam int GUARD       = 8;
   localparam int XW          = VEC_W + GUARD + 2;
   localparam int PROD_W      = 2 * VEC_W;
   localparam int PROD_SHIFT  = GAIN_FRAC - GUARD;
   localparam int TABLE_LEN   = 32;

   localparam logic signed [63:0] PI_Q30      = 64'sd3373259426;
   localparam logic signed [63:0] HALF_PI_Q30 = 64'sd1686629713;
   localparam logic signed [63:0] TWO_PI_Q30  = 64'sd6746518852;

   localparam logic signed [VEC_W-1:0] OUT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VEC_W-1:0] OUT_MIN = 32'sh8000_0000;

   localparam logic signed [63:0] ATAN_Q30 [TABLE_LEN] = '{
      64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
      64'sd67021687,  64'sd33543516,  64'sd16775851,  64'sd8388437,
      64'sd4194283,   64'sd2097149,   64'sd1048576,   64'sd524288,
      64'sd262144,    64'sd131072,    64'sd65536,     64'sd32768,
      64'sd16384,     64'sd8192,      64'sd4096,      64'sd2048,
      64'sd1024,      64'sd512,       64'sd256,       64'sd128,
      64'sd64,        64'sd32,        64'sd16,        64'sd8,
      64'sd4,         64'sd2,         64'sd1,         64'sd0
   };

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
   } vec_type;

   // q30 constant to q.frac, arithmetic right shift when narrowing
   function automatic logic signed [63:0] rescale_q30(logic signed [63:0] v, int frac);
      logic signed [63:0] r;
      if (frac >= GAIN_FRAC) begin
         r = v <<< (frac - GAIN_FRAC);
      end else begin
         r = v >>> (GAIN_FRAC - frac);
      end
      return r;
   endfunction

   // gain compensation in q1.30: q60 product, integer root, rounded long division
   function automatic logic [63:0] gain_q30(int iters);
      logic [63:0] p;
      logic [63:0] n;
      logic [63:0] res;
      logic [63:0] bit_v;
      logic [63:0] s;
      logic [63:0] num;
      logic [63:0] rem;
      logic [63:0] quo;
      p = 64'd1 << 60;
      for (int i = 0; i < TABLE_LEN; i++) begin
         if (i < iters) begin
            p = p + (p >> (2 * i));
         end
      end
      n     = p;
      res   = '0;
      bit_v = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (bit_v > n) begin
            bit_v = bit_v >> 2;
         end
      end
      for (int i = 0; i < 32; i++) begin
         if (bit_v != 64'd0) begin
            if (n >= res + bit_v) begin
               n   = n - (res + bit_v);
               res = (res >> 1) + bit_v;
            end else begin
               res = res >> 1;
            end
            bit_v = bit_v >> 2;
         end
      end
      s   = (res == 64'd0) ? 64'd1 : res;
      num = (64'd1 << 60) + (s >> 1);
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= s) begin
            rem    = rem - s;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

endpackage

// File: hdl/v2r_scale.sv
// entry stage: gain compensation multiply and angle fold into one turn
module v2r_scale #(
   parameter int ITERATIONS = v2r_pkg::ITERATIONS_DEF,
   parameter int DATA_WIDTH = v2r_pkg::DATA_WIDTH_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    load,
   input  logic                                    in_valid,
   input  logic signed [v2r_pkg::VEC_W-1:0]        in_x,
   input  logic signed [v2r_pkg::VEC_W-1:0]        in_y,
   input  logic signed [v2r_pkg::ANG_W-1:0]        in_angle,
   output logic                                    out_valid,
   output v2r_pkg::vec_type                        out_vec,
   output logic signed [DATA_WIDTH+2:0]            out_z
);
   import v2r_pkg::*;

   localparam int ZW   = DATA_WIDTH + 3;
   localparam int FRAC = DATA_WIDTH - 2;
   localparam int LSH  = (FRAC >= ANG_IN_FRAC) ? FRAC - ANG_IN_FRAC : 0;
   localparam int RSH  = (FRAC >= ANG_IN_FRAC) ? 0 : ANG_IN_FRAC - FRAC;
   localparam logic [63:0] GAIN64 = gain_q30(ITERATIONS);
   localparam logic signed [ZW-1:0] PI_Z  = ZW'(rescale_q30(PI_Q30, FRAC));
   localparam logic signed [ZW-1:0] TPI_Z = ZW'(rescale_q30(TWO_PI_Q30, FRAC));

   logic signed [VEC_W-1:0]  gain_s;
   logic signed [PROD_W-1:0] prod_x;
   logic signed [PROD_W-1:0] prod_y;
   logic signed [63:0]       z_ext;
   logic signed [ZW-1:0]     z_scaled;

   logic          valid_ff;
   vec_type       vec_ff;
   vec_type       vec_in;
   logic signed [ZW-1:0] z_ff;
   logic signed [ZW-1:0] z_in;

   assign gain_s = $signed(GAIN64[VEC_W-1:0]);
   assign prod_x = in_x * gain_s;
   assign prod_y = in_y * gain_s;
   assign z_ext    = 64'(in_angle);
   assign z_scaled = ZW'((z_ext <<< LSH) >>> RSH);

   always_comb begin
      vec_in.x = prod_x[PROD_SHIFT +: XW];
      vec_in.y = prod_y[PROD_SHIFT +: XW];
      if (z_scaled > PI_Z) begin
         z_in = z_scaled - TPI_Z;
      end else if (z_scaled < -PI_Z) begin
         z_in = z_scaled + TPI_Z;
      end else begin
         z_in = z_scaled;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         vec_ff <= vec_in;
         z_ff   <= z_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;
   assign out_z     = z_ff;

endmodule

// File: hdl/v2r_quad.sv
// quarter-turn pre-rotation bringing the angle into the half plane
module v2r_quad #(
   parameter int DATA_WIDTH = v2r_pkg::DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  logic                         in_valid,
   input  v2r_pkg::vec_type             in_vec,
   input  logic signed [DATA_WIDTH+2:0] in_z,
   output logic                         out_valid,
   output v2r_pkg::vec_type             out_vec,
   output logic signed [DATA_WIDTH+2:0] out_z
);
   import v2r_pkg::*;

   localparam int ZW   = DATA_WIDTH + 3;
   localparam int FRAC = DATA_WIDTH - 2;
   localparam logic signed [ZW-1:0] HPI_Z = ZW'(rescale_q30(HALF_PI_Q30, FRAC));

   logic          valid_ff;
   vec_type       vec_ff;
   vec_type       vec_in;
   logic signed [ZW-1:0] z_ff;
   logic signed [ZW-1:0] z_in;

   always_comb begin
      if (in_z > HPI_Z) begin
         vec_in.x = -in_vec.y;
         vec_in.y = in_vec.x;
         z_in     = in_z - HPI_Z;
      end else if (in_z < -HPI_Z) begin
         vec_in.x = in_vec.y;
         vec_in.y = -in_vec.x;
         z_in     = in_z + HPI_Z;
      end else begin
         vec_in = in_vec;
         z_in   = in_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         vec_ff <= vec_in;
         z_ff   <= z_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;
   assign out_z     = z_ff;

endmodule

// File: hdl/v2r_cell.sv
// one cordic micro-rotation cell with its stage register
module v2r_cell #(
   parameter int IDX        = 0,
   parameter int DATA_WIDTH = v2r_pkg::DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  logic                         in_valid,
   input  v2r_pkg::vec_type             in_vec,
   input  logic signed [DATA_WIDTH+2:0] in_z,
   output logic                         out_valid,
   output v2r_pkg::vec_type             out_vec,
   output logic signed [DATA_WIDTH+2:0] out_z
);
   import v2r_pkg::*;

   localparam int ZW   = DATA_WIDTH + 3;
   localparam int FRAC = DATA_WIDTH - 2;
   localparam logic signed [ZW-1:0] ATAN_Z = ZW'(rescale_q30(ATAN_Q30[IDX], FRAC));

   logic signed [XW-1:0] dx;
   logic signed [XW-1:0] dy;

   logic          valid_ff;
   vec_type       vec_ff;
   vec_type       vec_in;
   logic signed [ZW-1:0] z_ff;
   logic signed [ZW-1:0] z_in;

   assign dx = $signed(in_vec.y) >>> IDX;
   assign dy = $signed(in_vec.x) >>> IDX;

   // zero residual counts as non-negative
   always_comb begin
      if (!in_z[ZW-1]) begin
         vec_in.x = in_vec.x - dx;
         vec_in.y = in_vec.y + dy;
         z_in     = in_z - ATAN_Z;
      end else begin
         vec_in.x = in_vec.x + dx;
         vec_in.y = in_vec.y - dy;
         z_in     = in_z + ATAN_Z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         vec_ff <= vec_in;
         z_ff   <= z_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;
   assign out_z     = z_ff;

endmodule

// File: hdl/v2r_round.sv
// output stage: drop guard bits with rounding and saturate to 32 bits
module v2r_round (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load,
   input  logic                             in_valid,
   input  v2r_pkg::vec_type                 in_vec,
   output logic                             out_valid,
   output logic signed [v2r_pkg::VEC_W-1:0] out_x,
   output logic signed [v2r_pkg::VEC_W-1:0] out_y,
   output logic                             out_sat
);
   import v2r_pkg::*;

   localparam int RW = XW - GUARD;
   localparam logic signed [XW-1:0] HALF_LSB = XW'(1) <<< (GUARD - 1);
   localparam logic signed [RW-1:0] MAX_R = RW'(OUT_MAX);
   localparam logic signed [RW-1:0] MIN_R = RW'(OUT_MIN);

   logic signed [XW-1:0] x_bias;
   logic signed [XW-1:0] y_bias;
   logic signed [RW-1:0] x_r;
   logic signed [RW-1:0] y_r;
   logic                 x_clip;
   logic                 y_clip;

   logic                    valid_ff;
   logic signed [VEC_W-1:0] x_ff;
   logic signed [VEC_W-1:0] x_in;
   logic signed [VEC_W-1:0] y_ff;
   logic signed [VEC_W-1:0] y_in;
   logic                    sat_ff;
   logic                    sat_in;

   assign x_bias = in_vec.x + HALF_LSB;
   assign y_bias = in_vec.y + HALF_LSB;
   assign x_r    = x_bias[XW-1:GUARD];
   assign y_r    = y_bias[XW-1:GUARD];

   always_comb begin
      x_clip = 1'b1;
      y_clip = 1'b1;
      if (x_r > MAX_R) begin
         x_in = OUT_MAX;
      end else if (x_r < MIN_R) begin
         x_in = OUT_MIN;
      end else begin
         x_in   = x_r[VEC_W-1:0];
         x_clip = 1'b0;
      end
      if (y_r > MAX_R) begin
         y_in = OUT_MAX;
      end else if (y_r < MIN_R) begin
         y_in = OUT_MIN;
      end else begin
         y_in   = y_r[VEC_W-1:0];
         y_clip = 1'b0;
      end
      sat_in = x_clip | y_clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         sat_ff <= sat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_sat   = sat_ff;

endmodule

// File: hdl/vec2_rotate.sv
// top level of the cordic vector rotator
//
//   channel  direction  transfer when            payload
//   req      in         req_valid & !req_stall   req_vec_x, req_vec_y, req_turn_angle
//   rsp      out        rsp_valid & !rsp_stall   rsp_rot_x, rsp_rot_y, rsp_saturated
//
// one transfer a cycle in each direction when no stall holds it; stages in order:
// scale stage, quarter-turn stage, one cell per micro-rotation, output stage
// reset clears every stage valid bit; no other start-up time
// a stall only holds the stages that are full up to the output, so empty
// stages keep filling and req_stall rises only once the whole chain is full
module vec2_rotate #(
   parameter int ITERATIONS = v2r_pkg::ITERATIONS_DEF,
   parameter int DATA_WIDTH = v2r_pkg::DATA_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [v2r_pkg::VEC_W-1:0] req_vec_x,
   input  logic signed [v2r_pkg::VEC_W-1:0] req_vec_y,
   input  logic signed [v2r_pkg::ANG_W-1:0] req_turn_angle,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [v2r_pkg::VEC_W-1:0] rsp_rot_x,
   output logic signed [v2r_pkg::VEC_W-1:0] rsp_rot_y,
   output logic                             rsp_saturated
);
   import v2r_pkg::*;

   localparam int ZW = DATA_WIDTH + 3;
   localparam int NS = ITERATIONS + 3;

   logic [NS-1:0]        stage_valid;
   logic [NS-1:0]        stage_load;
   vec_type              stage_vec [NS-1];
   logic signed [ZW-1:0] stage_z   [NS-1];

   // a stage may load when some stage at or after it is empty or the output moves on
   for (genvar k = 0; k < NS; k++) begin : g_load
      assign stage_load[k] = ~rsp_stall | ~(&stage_valid[NS-1:k]);
   end

   assign req_stall = ~stage_load[0];
   assign rsp_valid = stage_valid[NS-1];

   v2r_scale #(
      .ITERATIONS (ITERATIONS),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .load      (stage_load[0]),
      .in_valid  (req_valid),
      .in_x      (req_vec_x),
      .in_y      (req_vec_y),
      .in_angle  (req_turn_angle),
      .out_valid (stage_valid[0]),
      .out_vec   (stage_vec[0]),
      .out_z     (stage_z[0])
   );

   v2r_quad #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_quad (
      .clock     (clock),
      .reset     (reset),
      .load      (stage_load[1]),
      .in_valid  (stage_valid[0]),
      .in_vec    (stage_vec[0]),
      .in_z      (stage_z[0]),
      .out_valid (stage_valid[1]),
      .out_vec   (stage_vec[1]),
      .out_z     (stage_z[1])
   );

   for (genvar c = 0; c < ITERATIONS; c++) begin : g_cell
      v2r_cell #(
         .IDX        (c),
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .load      (stage_load[c+2]),
         .in_valid  (stage_valid[c+1]),
         .in_vec    (stage_vec[c+1]),
         .in_z      (stage_z[c+1]),
         .out_valid (stage_valid[c+2]),
         .out_vec   (stage_vec[c+2]),
         .out_z     (stage_z[c+2])
      );
   end

   v2r_round u_round (
      .clock     (clock),
      .reset     (reset),
      .load      (stage_load[NS-1]),
      .in_valid  (stage_valid[NS-2]),
      .in_vec    (stage_vec[NS-2]),
      .out_valid (stage_valid[NS-1]),
      .out_x     (rsp_rot_x),
      .out_y     (rsp_rot_y),
      .out_sat   (rsp_saturated)
   );

endmodule

// File: tb/sv/vec2_rotate_check.sv
// checker for the vector rotator: watches both channels, predicts each result and compares
module vec2_rotate_check (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic signed [v2r_pkg::VEC_W-1:0] req_vec_x,
   input  logic signed [v2r_pkg::VEC_W-1:0] req_vec_y,
   input  logic signed [v2r_pkg::ANG_W-1:0] req_turn_angle,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic signed [v2r_pkg::VEC_W-1:0] rsp_rot_x,
   input  logic signed [v2r_pkg::VEC_W-1:0] rsp_rot_y,
   input  logic                             rsp_saturated,
   output int                               n_pending,
   output int                               n_fail
);

   localparam int ITERS      = v2r_pkg::ITERATIONS_DEF;
   localparam int ANG_FRAC   = v2r_pkg::DATA_WIDTH_DEF - 2;
   localparam int K_FRAC     = 30;
   localparam int GUARD_BITS = 8;
   localparam int IN_FRAC    = 16;

   localparam longint PI_C      = 64'sd3373259426;
   localparam longint HALF_PI_C = 64'sd1686629713;
   localparam longint TWO_PI_C  = 64'sd6746518852;

   localparam longint ATAN_TBL [32] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
      16, 8, 4, 2, 1, 0
   };

   typedef struct packed {
      logic signed [v2r_pkg::VEC_W-1:0] rot_x;
      logic signed [v2r_pkg::VEC_W-1:0] rot_y;
      logic                             saturated;
   } rot_result_type;

   rot_result_type pending_rot [$];
   rot_result_type want;
   longint         gain_k;
   int             fails;

   function automatic longint calc_gain();
      logic [63:0] p;
      logic [63:0] n;
      logic [63:0] root;
      logic [63:0] b;
      logic [63:0] s;
      p = 64'd1 << 60;
      for (int i = 0; i < ITERS && i < 32; i++) begin
         p = p + (p >> (2 * i));
      end
      n    = p;
      root = '0;
      b    = 64'd1 << 62;
      while (b > n) begin
         b = b >> 2;
      end
      while (b != 64'd0) begin
         if (n >= root + b) begin
            n    = n - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      s = (root == 64'd0) ? 64'd1 : root;
      return longint'(((64'd1 << 60) + (s >> 1)) / s);
   endfunction

   function automatic longint to_ang_frac(longint v, int from);
      if (ANG_FRAC >= from) begin
         return v <<< (ANG_FRAC - from);
      end
      return v >>> (from - ANG_FRAC);
   endfunction

   function automatic longint clip_vec(longint v, inout logic sat);
      if (v > longint'(v2r_pkg::OUT_MAX)) begin
         sat = 1'b1;
         return longint'(v2r_pkg::OUT_MAX);
      end
      if (v < longint'(v2r_pkg::OUT_MIN)) begin
         sat = 1'b1;
         return longint'(v2r_pkg::OUT_MIN);
      end
      return v;
   endfunction

   function automatic rot_result_type rotate_vector(logic signed [v2r_pkg::VEC_W-1:0] vx,
                                                    logic signed [v2r_pkg::VEC_W-1:0] vy,
                                                    logic signed [v2r_pkg::ANG_W-1:0] ang);
      longint         x;
      longint         y;
      longint         z;
      longint         t;
      longint         dx;
      longint         dy;
      longint         pi_a;
      longint         hpi_a;
      logic           sat;
      rot_result_type r;
      sat   = 1'b0;
      pi_a  = to_ang_frac(PI_C, K_FRAC);
      hpi_a = to_ang_frac(HALF_PI_C, K_FRAC);
      z     = to_ang_frac(longint'(ang), IN_FRAC);
      x     = (longint'(vx) * gain_k) >>> (K_FRAC - GUARD_BITS);
      y     = (longint'(vy) * gain_k) >>> (K_FRAC - GUARD_BITS);
      if (z > pi_a) begin
         z = z - to_ang_frac(TWO_PI_C, K_FRAC);
      end else if (z < -pi_a) begin
         z = z + to_ang_frac(TWO_PI_C, K_FRAC);
      end
      // quarter turn into the cordic convergence range
      if (z > hpi_a) begin
         t = x;
         x = -y;
         y = t;
         z = z - hpi_a;
      end else if (z < -hpi_a) begin
         t = x;
         x = y;
         y = -t;
         z = z + hpi_a;
      end
      for (int i = 0; i < ITERS && i < 32; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - to_ang_frac(ATAN_TBL[i], K_FRAC);
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + to_ang_frac(ATAN_TBL[i], K_FRAC);
         end
      end
      x = (x + (64'sd1 <<< (GUARD_BITS - 1))) >>> GUARD_BITS;
      y = (y + (64'sd1 <<< (GUARD_BITS - 1))) >>> GUARD_BITS;
      x = clip_vec(x, sat);
      y = clip_vec(y, sat);
      r.rot_x     = x[v2r_pkg::VEC_W-1:0];
      r.rot_y     = y[v2r_pkg::VEC_W-1:0];
      r.saturated = sat;
      return r;
   endfunction

   initial begin
      gain_k = calc_gain();
      fails  = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         n_pending <= 0;
         n_fail    <= fails;
      end else begin
         // output side first: a result is registered, so it never leaves with its own request
         if (rsp_valid && !rsp_stall) begin
            if (pending_rot.size() == 0) begin
               fails++;
               if (fails <= 10) begin
                  $display("unexpected result transfer: x %0d y %0d sat %0d",
                           rsp_rot_x, rsp_rot_y, rsp_saturated);
               end
            end else begin
               want = pending_rot.pop_front();
               if (want.rot_x !== rsp_rot_x || want.rot_y !== rsp_rot_y ||
                   want.saturated !== rsp_saturated) begin
                  fails++;
                  if (fails <= 10) begin
                     $display("mismatch: x exp %0d got %0d, y exp %0d got %0d, sat exp %0d got %0d",
                              want.rot_x, rsp_rot_x, want.rot_y, rsp_rot_y,
                              want.saturated, rsp_saturated);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            pending_rot.push_back(rotate_vector(req_vec_x, req_vec_y, req_turn_angle));
         end
         n_pending <= pending_rot.size();
         n_fail    <= fails;
      end
   end

endmodule

// File: tb/sv/vec2_rotate_tb.sv
// testbench top for the vector rotator: clock, reset, stimulus and verdict
module vec2_rotate_tb;

   localparam int PHASE_ITEMS = 476;
   localparam int LIMIT       = 300000;
   localparam int SETTLE      = v2r_pkg::ITERATIONS_DEF + 3 + 8;
   localparam int AW          = v2r_pkg::ANG_W;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic signed [v2r_pkg::VEC_W-1:0] req_vec_x;
   logic signed [v2r_pkg::VEC_W-1:0] req_vec_y;
   logic signed [v2r_pkg::ANG_W-1:0] req_turn_angle;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic signed [v2r_pkg::VEC_W-1:0] rsp_rot_x;
   logic signed [v2r_pkg::VEC_W-1:0] rsp_rot_y;
   logic                             rsp_saturated;

   int n_pending;
   int n_fail;
   int send_idle_pct;
   int rsp_idle_pct;
   int cycle_cnt;

   vec2_rotate u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_vec_x      (req_vec_x),
      .req_vec_y      (req_vec_y),
      .req_turn_angle (req_turn_angle),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_rot_x      (rsp_rot_x),
      .rsp_rot_y      (rsp_rot_y),
      .rsp_saturated  (rsp_saturated)
   );

   vec2_rotate_check u_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_vec_x      (req_vec_x),
      .req_vec_y      (req_vec_y),
      .req_turn_angle (req_turn_angle),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_rot_x      (rsp_rot_x),
      .rsp_rot_y      (rsp_rot_y),
      .rsp_saturated  (rsp_saturated),
      .n_pending      (n_pending),
      .n_fail         (n_fail)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   initial begin
      cycle_cnt = 0;
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_vec(input logic signed [v2r_pkg::VEC_W-1:0] x,
                           input logic signed [v2r_pkg::VEC_W-1:0] y,
                           input logic signed [v2r_pkg::ANG_W-1:0] a);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid      <= 1'b1;
      req_vec_x      <= x;
      req_vec_y      <= y;
      req_turn_angle <= a;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (n_pending != 0);
   endtask

   function automatic logic signed [v2r_pkg::VEC_W-1:0] pick_vec();
      case ($urandom_range(9))
         0, 1, 2, 3: return $urandom;
         4, 5, 6:    return $signed($urandom) >>> 11;
         7: begin
            case ($urandom_range(4))
               0:       return v2r_pkg::OUT_MAX;
               1:       return v2r_pkg::OUT_MIN;
               2:       return 0;
               3:       return -1;
               default: return 1;
            endcase
         end
         default: return $signed($urandom) >>> 2;
      endcase
   endfunction

   function automatic logic signed [v2r_pkg::ANG_W-1:0] pick_ang();
      int d;
      d = $urandom_range(6);
      d = d - 3;
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: return AW'($urandom);
         6, 7: begin
            // around the folding and quarter-turn points
            case ($urandom_range(4))
               0:       return AW'(205887 + d);
               1:       return AW'(-205888 + d);
               2:       return AW'(102944 + d);
               3:       return AW'(-102944 + d);
               default: return AW'(d);
            endcase
         end
         8:       return $urandom_range(1) ? 20'sh7FFFF : 20'sh80000;
         default: return AW'($signed($urandom) >>> 24);
      endcase
   endfunction

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_vec_x      = '0;
      req_vec_y      = '0;
      req_turn_angle = '0;
      rsp_stall      = 1'b0;
      send_idle_pct  = 0;
      rsp_idle_pct   = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_vec(0, 0, 20'sd0);
      send_vec(v2r_pkg::OUT_MAX, 0, 20'sd0);
      send_vec(v2r_pkg::OUT_MIN, 0, 20'sd0);
      send_vec(0, v2r_pkg::OUT_MIN, 20'sd0);
      send_vec(v2r_pkg::OUT_MAX, v2r_pkg::OUT_MAX, 20'sd0);
      send_vec(v2r_pkg::OUT_MIN, v2r_pkg::OUT_MIN, 20'sd51472);
      send_vec(v2r_pkg::OUT_MAX, v2r_pkg::OUT_MAX, 20'sd51472);
      send_vec(v2r_pkg::OUT_MIN, v2r_pkg::OUT_MAX, 20'sh7FFFF);
      send_vec(v2r_pkg::OUT_MAX, v2r_pkg::OUT_MIN, 20'sh80000);
      send_vec(65536, 0, 20'sd205887);
      send_vec(65536, 0, 20'sd205888);
      send_vec(65536, 0, -20'sd205887);
      send_vec(65536, 0, -20'sd205888);
      send_vec(65536, 32768, 20'sd102943);
      send_vec(65536, 32768, 20'sd102944);
      send_vec(65536, 32768, -20'sd102943);
      send_vec(65536, 32768, -20'sd102944);
      send_vec(-65536, 65536, 20'sd1);
      send_vec(-65536, 65536, -20'sd1);
      send_vec(1, -1, 20'sd0);
      send_vec(-1, 1, 20'sd102944);
      send_vec(32'sh4000_0000, 32'sh4000_0000, 20'sh7FFFF);
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 7;
               rsp_idle_pct  = 75;
            end
            1: begin
               send_idle_pct = 75;
               rsp_idle_pct  = 7;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
            end
         endcase
         repeat (PHASE_ITEMS) begin
            send_vec(pick_vec(), pick_vec(), pick_ang());
         end
         drain();
      end

      repeat (SETTLE) @(posedge clock);
      if (n_fail == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
